// ===== sv/bsn_pkg.sv =====
// Shared types, constants and helpers of the bit set with find-next-set-bit.
// Depends on nothing; every other file of the block but bsn_ram uses it.
package bsn_pkg;

    // Fixed field widths of the item channels
    localparam int POS_W  = 12;
    localparam int KIND_W = 2;

    // Widest word the store supports and the bit offset width it needs
    localparam int WORD_MAX = 64;
    localparam int BIT_W    = 6;

    // Default geometry of the store
    localparam int WORDS_DEF     = 64;
    localparam int WORD_BITS_DEF = 64;

    // Command queue between the front and the back end
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_SET       = 2'd0,
        KIND_CLEAR     = 2'd1,
        KIND_FIND      = 2'd2,
        KIND_CLEAR_ALL = 2'd3
    } t_kind;

    // Classified command handed from the front to the back end
    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   widx;
        logic [BIT_W-1:0]   bit_pos;
        logic               in_cap;
    } t_cmd;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Offset of the lowest set bit of a word, zero for an empty word
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_MAX-1:0] w);
        logic [BIT_W-1:0] res;
        res = '0;
        for (int i = WORD_MAX - 1; i >= 0; i--) begin
            if (w[i]) begin
                res = BIT_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== sv/bsn_if.sv =====
// Valid/ready channel interfaces for items in and results out.
// Depends on bsn_pkg for the field widths.
interface bsn_in_if;
    logic                           valid;
    logic                           ready;
    logic [bsn_pkg::KIND_W-1:0]     kind;
    logic [bsn_pkg::POS_W-1:0]      position;

    modport source (output valid, output kind, output position, input ready);
    modport sink   (input valid, input kind, input position, output ready);
endinterface

interface bsn_out_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [bsn_pkg::POS_W-1:0]      bit_index;

    modport source (output valid, output found, output bit_index, input ready);
    modport sink   (input valid, input found, input bit_index, output ready);
endinterface

// ===== sv/bitset_with_next_set_bit.sv =====
// Top level of the bit set with find-next-set-bit.
// Depends on bsn_pkg, bsn_if, bsn_ram, bsn_front, bsn_queue and bsn_back.
//
// Items arrive on i_in (kind, position) and each gives exactly one result
// on o_out (found, bit_index), in order. Set, clear and clear-all report
// found = 0 and bit_index = 0; a search reports the lowest set bit at or
// after the position below the used-word mark.
// The front end splits the position into word and bit offset and feeds a
// two-entry command queue; the back end works one command at a time on a
// single-port-read RAM of WORDS words.
// A set beyond the capacity and a clear or search at or beyond the used-word
// mark skip the store; a search walks the words from its own to the mark.
// Back-end occupancy sets the rate; a search reads one RAM word per cycle.
// After reset the back end zeroes the store, one word a cycle; the front
// accepts items meanwhile until the queue and the front stage fill.
// A stalled receiver holds the result in the output register; the back end
// then waits, and the queue and front fill before i_in.ready drops.
module bitset_with_next_set_bit #(
    parameter int WORDS     = bsn_pkg::WORDS_DEF,
    parameter int WORD_BITS = bsn_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsn_in_if.sink      i_in,
    bsn_out_if.source   o_out
);

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic                   q_push;
    logic                   q_pop;
    bsn_pkg::t_cmd          q_in;
    bsn_pkg::t_cmd          q_out;
    bsn_pkg::t_q_status     q_status;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [WORD_BITS-1:0]   wr_data;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [WORD_BITS-1:0]   rd_data;

    bsn_front #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_status.full),
        .o_push   (q_push),
        .o_cmd    (q_in)
    );

    bsn_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_status)
    );

    bsn_back #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!q_status.empty),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out       (o_out)
    );

    bsn_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // The front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_status.full))
        else $error("command queue overflow");

    // The back end never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_pop && q_status.empty))
        else $error("command queue underflow");

    // A result that reports nothing found carries a zero index
    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.found) |-> (o_out.bit_index == '0))
        else $error("nonzero index without a found bit");

endmodule

// ===== sv/bsn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bsn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write, then register the read word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/bsn_front.sv =====
// Front end: accepts items and splits the position into word and bit offset.
// Depends on bsn_pkg and bsn_in_if.
module bsn_front #(
    parameter int WORDS     = bsn_pkg::WORDS_DEF,
    parameter int WORD_BITS = bsn_pkg::WORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bsn_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output bsn_pkg::t_cmd   o_cmd
);

    // Division by the word width as a multiply by a rounded-up reciprocal;
    // exact for every 12-bit position.
    localparam int SH    = 24;
    localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
    localparam int PW    = SH + bsn_pkg::POS_W;

    logic                           r_a_valid;
    logic                           n_a_valid;
    bsn_pkg::t_kind                 r_a_kind;
    logic [bsn_pkg::POS_W-1:0]      r_a_pos;
    logic [PW-1:0]                  r_a_prod;
    logic                           a_free;
    logic                           accept;
    logic [bsn_pkg::POS_W-1:0]      quot;
    logic [bsn_pkg::POS_W-1:0]      q_base;
    logic [bsn_pkg::POS_W-1:0]      rem;

    assign a_free     = !r_a_valid || !i_q_full;
    assign i_in.ready = a_free;
    assign accept     = i_in.valid && a_free;
    assign o_push     = r_a_valid && !i_q_full;

    // Hold the stage while the queue is full, refill it on accept
    always_comb begin
        n_a_valid = r_a_valid;
        if (accept) begin
            n_a_valid = 1'b1;
        end else if (o_push) begin
            n_a_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_kind <= bsn_pkg::t_kind'(i_in.kind);
            r_a_pos  <= i_in.position;
            r_a_prod <= PW'(i_in.position) * PW'(RECIP);
        end
    end

    // Word index, bit offset and capacity check
    assign quot   = r_a_prod[SH +: bsn_pkg::POS_W];
    assign q_base = bsn_pkg::POS_W'(quot * bsn_pkg::POS_W'(WORD_BITS));
    assign rem    = r_a_pos - q_base;

    always_comb begin
        o_cmd.kind    = r_a_kind;
        o_cmd.widx    = quot;
        o_cmd.bit_pos = rem[bsn_pkg::BIT_W-1:0];
        o_cmd.in_cap  = (32'(quot) < 32'(WORDS));
    end

endmodule

// ===== sv/bsn_queue.sv =====
// Short command queue between the front and the back end.
// Depends on bsn_pkg for the command type and depth.
module bsn_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  bsn_pkg::t_cmd           i_data,
    input  logic                    i_pop,
    output bsn_pkg::t_cmd           o_data,
    output bsn_pkg::t_q_status      o_status
);

    bsn_pkg::t_cmd                  r_mem [bsn_pkg::Q_DEPTH];
    logic [bsn_pkg::Q_AW-1:0]       r_wr_ptr;
    logic [bsn_pkg::Q_AW-1:0]       r_rd_ptr;
    logic [bsn_pkg::Q_AW:0]         r_count;
    logic [bsn_pkg::Q_AW-1:0]       n_wr_ptr;
    logic [bsn_pkg::Q_AW-1:0]       n_rd_ptr;
    logic [bsn_pkg::Q_AW:0]         n_count;

    // Advance the pointers; the depth is a power of two so they wrap freely
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == (bsn_pkg::Q_AW + 1)'(bsn_pkg::Q_DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ===== sv/bsn_back.sv =====
// Back end: carries out commands on the word store and drives the results.
// Depends on bsn_pkg, bsn_out_if and an external bsn_ram for the words.
module bsn_back #(
    parameter int WORDS     = bsn_pkg::WORDS_DEF,
    parameter int WORD_BITS = bsn_pkg::WORD_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cmd_valid,
    input  bsn_pkg::t_cmd                               i_cmd,
    output logic                                        o_cmd_pop,
    output logic                                        o_wr_en,
    output logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] o_wr_addr,
    output logic [WORD_BITS-1:0]                        o_wr_data,
    output logic                                        o_rd_en,
    output logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] o_rd_addr,
    input  logic [WORD_BITS-1:0]                        i_rd_data,
    bsn_out_if.source                                   o_out
);

    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int UW = $clog2(WORDS + 1);
    localparam int BW = $clog2(WORD_BITS);
    localparam int IW = AW + bsn_pkg::BIT_W + 2;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_RMW    = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_CLEAR  = 6'b001000,
        ST_INDEX  = 6'b010000,
        ST_RESULT = 6'b100000
    } t_state;

    t_state                         r_state, n_state;
    bsn_pkg::t_kind                 r_kind, n_kind;
    logic [AW-1:0]                  r_cnt, n_cnt;
    logic [BW-1:0]                  r_bit, n_bit;
    logic [UW-1:0]                  r_used, n_used;
    logic [WORD_BITS-1:0]           r_mask, n_mask;
    logic [bsn_pkg::BIT_W-1:0]      r_lb, n_lb;
    logic                           r_res_found, n_res_found;
    logic [bsn_pkg::POS_W-1:0]      r_res_index, n_res_index;
    logic                           r_emit, n_emit;
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_found, n_out_found;
    logic [bsn_pkg::POS_W-1:0]      r_out_index, n_out_index;

    logic [WORD_BITS-1:0]           scan_word;
    logic                           hit;
    logic [UW-1:0]                  cnt_next;
    logic                           more;
    logic                           in_used;
    logic [WORD_BITS-1:0]           bit_sel;
    logic [IW-1:0]                  idx_full;

    assign scan_word = i_rd_data & r_mask;
    assign hit       = |scan_word;
    assign cnt_next  = UW'(r_cnt) + UW'(1);
    assign more      = (cnt_next < r_used);
    assign in_used   = (i_cmd.widx < bsn_pkg::POS_W'(r_used));
    assign bit_sel   = WORD_BITS'(1) << r_bit;
    assign idx_full  = IW'(r_cnt) * IW'(WORD_BITS) + IW'(r_lb);

    // Sequence one command at a time over the store
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_cnt       = r_cnt;
        n_bit       = r_bit;
        n_used      = r_used;
        n_mask      = r_mask;
        n_lb        = r_lb;
        n_res_found = r_res_found;
        n_res_index = r_res_index;
        n_emit      = r_emit;
        n_out_valid = r_out_valid;
        n_out_found = r_out_found;
        n_out_index = r_out_index;
        o_cmd_pop   = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_cnt;
        o_wr_data   = '0;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_cnt;

        // Drop the result once the receiver takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop   = 1'b1;
                    n_kind      = i_cmd.kind;
                    n_bit       = i_cmd.bit_pos[BW-1:0];
                    n_cnt       = i_cmd.widx[AW-1:0];
                    n_mask      = {WORD_BITS{1'b1}} << i_cmd.bit_pos[BW-1:0];
                    n_res_found = 1'b0;
                    n_res_index = '0;
                    o_rd_addr   = i_cmd.widx[AW-1:0];
                    case (i_cmd.kind)
                        bsn_pkg::KIND_SET: begin
                            o_rd_en = i_cmd.in_cap;
                            n_state = i_cmd.in_cap ? ST_RMW : ST_RESULT;
                        end
                        bsn_pkg::KIND_CLEAR: begin
                            o_rd_en = in_used;
                            n_state = in_used ? ST_RMW : ST_RESULT;
                        end
                        bsn_pkg::KIND_FIND: begin
                            o_rd_en = in_used;
                            n_state = in_used ? ST_SCAN : ST_RESULT;
                        end
                        bsn_pkg::KIND_CLEAR_ALL: begin
                            n_emit  = 1'b1;
                            n_cnt   = '0;
                            n_state = (r_used == '0) ? ST_RESULT : ST_CLEAR;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_RMW: begin
                // Write back the word with the bit set or cleared
                o_wr_en = 1'b1;
                if (r_kind == bsn_pkg::KIND_SET) begin
                    o_wr_data = i_rd_data | bit_sel;
                    if (cnt_next > r_used) begin
                        n_used = cnt_next;
                    end
                end else begin
                    o_wr_data = i_rd_data & ~bit_sel;
                end
                n_state = ST_RESULT;
            end
            ST_SCAN: begin
                // Check the word read last cycle, fetch the next one
                if (hit) begin
                    n_lb    = bsn_pkg::lowest_bit(bsn_pkg::WORD_MAX'(scan_word));
                    n_state = ST_INDEX;
                end else if (more) begin
                    n_cnt     = cnt_next[AW-1:0];
                    o_rd_en   = 1'b1;
                    o_rd_addr = cnt_next[AW-1:0];
                    n_mask    = {WORD_BITS{1'b1}};
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_INDEX: begin
                n_res_found = 1'b1;
                n_res_index = idx_full[bsn_pkg::POS_W-1:0];
                n_state     = ST_RESULT;
            end
            ST_CLEAR: begin
                // Zero one word a cycle up to the used mark
                o_wr_en = 1'b1;
                if (cnt_next == r_used) begin
                    n_used  = '0;
                    n_state = r_emit ? ST_RESULT : ST_IDLE;
                end else begin
                    n_cnt = cnt_next[AW-1:0];
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_res_found;
                    n_out_index = r_res_index;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Reset starts a clearing pass over the whole store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_used      <= UW'(WORDS);
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_used      <= n_used;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_bit       <= n_bit;
        r_mask      <= n_mask;
        r_lb        <= n_lb;
        r_res_found <= n_res_found;
        r_res_index <= n_res_index;
        r_out_found <= n_out_found;
        r_out_index <= n_out_index;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.found     = r_out_found;
    assign o_out.bit_index = r_out_index;

endmodule
